@@ sv/ptpd_pkg.sv @@
package ptpd_pkg;

  localparam int MAX_LINE_WIDTH = 8192;
  localparam int LW_W = 14;
  localparam int COL_W = 13;
  localparam int DOT_W = 27;
  localparam int SUM_W = 10;

  localparam logic [DOT_W-1:0] DOT_MAX = {DOT_W{1'b1}};
  localparam logic [LW_W-1:0] LW_RESET = LW_W'(4960);
  localparam logic [LW_W-1:0] LW_MAX = LW_W'(MAX_LINE_WIDTH);

  localparam logic [7:0] GRAY_THRESHOLD = 8'd128;
  // (r+g+b)/3 < 128  <=>  sum < 384 ; (r+g+b)/3 > 128  <=>  sum >= 387
  localparam logic [SUM_W-1:0] SUM_BELOW = SUM_W'(3 * 128);
  localparam logic [SUM_W-1:0] SUM_ABOVE = SUM_W'(3 * 128 + 3);

  typedef logic [7:0] chan_t;
  typedef logic [LW_W-1:0] width_t;
  typedef logic [DOT_W-1:0] dot_t;

  typedef enum logic [1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_SUBTRACTIVE  = 2'd1,
    CFG_LINE_WIDTH   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic   pixel_format;
    logic   subtractive_space;
    width_t line_width;
  } cfg_t;

  typedef struct packed {
    chan_t packed_byte;
    logic  row_end;
    logic  page_end;
    dot_t  dot_total;
  } res_t;

endpackage

@@ sv/ptpd_if.sv @@
interface ptpd_pix_if;
  logic            valid;
  logic            ready;
  ptpd_pkg::chan_t chan_a;
  ptpd_pkg::chan_t chan_b;
  ptpd_pkg::chan_t chan_c;
  logic            page_final;

  modport source(output valid, output chan_a, output chan_b, output chan_c,
                 output page_final, input ready);
  modport sink(input valid, input chan_a, input chan_b, input chan_c,
               input page_final, output ready);
endinterface

interface ptpd_byte_if;
  logic            valid;
  logic            ready;
  ptpd_pkg::chan_t packed_byte;
  logic            row_end;
  logic            page_end;
  ptpd_pkg::dot_t  dot_total;

  modport source(output valid, output packed_byte, output row_end, output page_end,
                 output dot_total, input ready);
  modport sink(input valid, input packed_byte, input row_end, input page_end,
               input dot_total, output ready);
endinterface

@@ sv/ptpd_classify.sv @@
module ptpd_classify (
  input  ptpd_pkg::chan_t chan_a,
  input  ptpd_pkg::chan_t chan_b,
  input  ptpd_pkg::chan_t chan_c,
  input  ptpd_pkg::cfg_t  cfg,
  output logic            black
);
  import ptpd_pkg::*;

  logic [SUM_W-1:0] sum;

  assign sum = SUM_W'(chan_a) + SUM_W'(chan_b) + SUM_W'(chan_c);

  always_comb begin
    if (cfg.pixel_format) begin
      black = cfg.subtractive_space ? (sum >= SUM_ABOVE) : (sum < SUM_BELOW);
    end else begin
      black = cfg.subtractive_space ? (chan_a > GRAY_THRESHOLD) : (chan_a < GRAY_THRESHOLD);
    end
  end
endmodule

@@ sv/ptpd_pack.sv @@
module ptpd_pack (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              step,
  input  logic              black,
  input  logic              last,
  input  ptpd_pkg::width_t  line_width,
  output logic              out_valid,
  output ptpd_pkg::res_t    res
);
  import ptpd_pkg::*;

  chan_t            acc_r, acc_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  dot_t             dot_r, dot_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  chan_t  acc_set;
  dot_t   dot_new;
  width_t col_new;
  width_t eff_w;
  logic   row_done;
  logic   emit;

  always_comb begin
    priority if (line_width == '0) begin
      eff_w = width_t'(1);
    end else if (line_width > LW_MAX) begin
      eff_w = LW_MAX;
    end else begin
      eff_w = line_width;
    end
  end

  assign acc_set  = black ? (acc_r | (8'h80 >> pos_r)) : acc_r;
  assign dot_new  = (black && dot_r != DOT_MAX) ? dot_r + dot_t'(1) : dot_r;
  assign col_new  = width_t'(col_r) + width_t'(1);
  assign row_done = (col_new >= eff_w) || last;
  assign emit     = (pos_r == 3'd7) || row_done;

  always_comb begin
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    col_nxt       = col_r;
    dot_nxt       = dot_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (advance) begin
      out_valid_nxt = step && emit;
    end
    if (step) begin
      if (emit) begin
        acc_nxt = '0;
        pos_nxt = '0;
        col_nxt = row_done ? '0 : col_new[COL_W-1:0];
        dot_nxt = last ? '0 : dot_new;
        res_nxt = '{packed_byte: acc_set, row_end: row_done, page_end: last,
                    dot_total: dot_new};
      end else begin
        acc_nxt = acc_set;
        pos_nxt = pos_r + 3'd1;
        col_nxt = col_new[COL_W-1:0];
        dot_nxt = dot_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pos_r       <= '0;
      col_r       <= '0;
      dot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      col_r       <= col_nxt;
      dot_r       <= dot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;
endmodule

@@ sv/pixel_threshold_pack_dotcount.sv @@
// Thresholds one pixel per beat (gray, or the truncated mean of RGB) at 128,
// packs black pixels MSB-first into bytes and keeps a saturating per-page
// black-dot count. A byte leaves after eight pixels, at row end (zero-padded)
// or at the page's last pixel; the count clears after the page's last byte.
// A pixel beat is taken every cycle while the output is not held; each pixel
// passes the input classify register, then the pack state and output register.
// Output backpressure stalls both stages; a pixel can still enter the empty input
// stage while a byte waits. Write cfg registers only while the block is idle.
module pixel_threshold_pack_dotcount (
  input  logic                clk,
  input  logic                rst_n,
  ptpd_pix_if.sink            in_pix,
  ptpd_byte_if.source         out_byte,
  input  logic                cfg_we,
  input  ptpd_pkg::cfg_idx_t  cfg_index,
  input  ptpd_pkg::width_t    cfg_wdata
);
  import ptpd_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_black_r, s1_black_nxt;
  logic s1_last_r, s1_last_nxt;

  logic black;
  logic advance;
  logic in_ready;
  logic step;
  logic pk_valid;
  res_t pk_res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT: cfg_nxt.pixel_format      = cfg_wdata[0];
        CFG_SUBTRACTIVE:  cfg_nxt.subtractive_space = cfg_wdata[0];
        CFG_LINE_WIDTH:   cfg_nxt.line_width        = cfg_wdata;
        default: ;
      endcase
    end
  end

  ptpd_classify u_classify (
    .chan_a (in_pix.chan_a),
    .chan_b (in_pix.chan_b),
    .chan_c (in_pix.chan_c),
    .cfg    (cfg_r),
    .black  (black)
  );

  assign advance  = !pk_valid || out_byte.ready;
  assign in_ready = !s1_valid_r || advance;
  assign step     = s1_valid_r && advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_black_nxt = s1_black_r;
    s1_last_nxt  = s1_last_r;
    if (in_ready) begin
      s1_valid_nxt = in_pix.valid;
      s1_black_nxt = black;
      s1_last_nxt  = in_pix.page_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= '{pixel_format: 1'b0, subtractive_space: 1'b0, line_width: LW_RESET};
      s1_valid_r <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_black_r <= s1_black_nxt;
    s1_last_r  <= s1_last_nxt;
  end

  ptpd_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .step       (step),
    .black      (s1_black_r),
    .last       (s1_last_r),
    .line_width (cfg_r.line_width),
    .out_valid  (pk_valid),
    .res        (pk_res)
  );

  assign in_pix.ready         = in_ready;
  assign out_byte.valid       = pk_valid;
  assign out_byte.packed_byte = pk_res.packed_byte;
  assign out_byte.row_end     = pk_res.row_end;
  assign out_byte.page_end    = pk_res.page_end;
  assign out_byte.dot_total   = pk_res.dot_total;
endmodule
